// ===== hdl/dlas_pkg.sv =====
// ----------------------------------------------------------------------------
// dlas_pkg: shared types and constants
// Action codes, the digit type and decimal constants used by the decimal
// long add/subtract block.
// ----------------------------------------------------------------------------
`default_nettype none

package dlas_pkg;

  typedef logic [3:0] digit_t;

  typedef enum logic [2:0] {
    ACT_APPEND_A = 3'd0,
    ACT_APPEND_B = 3'd1,
    ACT_SUM      = 3'd2,
    ACT_DIFF     = 3'd3,
    ACT_CLEAR    = 3'd4
  } action_e;

  // Radix in the width of a digit sum with carry
  localparam logic [4:0] RADIX = 5'd10;

  // Largest decimal digit; stored digits saturate to it
  localparam digit_t DIGIT_MAX = 4'd9;

  // Digit written when a sum carries out of the top position
  localparam digit_t DIGIT_ONE = 4'd1;

endpackage

`default_nettype wire

// ===== hdl/dlas_operand.sv =====
// ----------------------------------------------------------------------------
// dlas_operand: operand digit store
// Holds one decimal number in arrival order (most significant digit first)
// with its digit count, and reads one digit per cycle by position counted
// from the least significant end. Positions at or above the count read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module dlas_operand #(
  parameter int MAX_DIGITS = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 clear_i,
  input  wire                                 append_i,
  input  dlas_pkg::digit_t                    digit_i,
  input  wire [$clog2(MAX_DIGITS + 1) - 1:0]  rd_pos_i,
  output logic [$clog2(MAX_DIGITS + 1) - 1:0] count_o,
  output dlas_pkg::digit_t                    rd_digit_o
);

  import dlas_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  digit_t          mem_q [MAX_DIGITS];
  logic [CW - 1:0] count_q, count_d;
  logic [CW - 1:0] rd_addr;
  digit_t          rd_q;
  logic            in_range_q;
  digit_t          wr_digit;

  // Saturate incoming digits to nine
  assign wr_digit = (digit_i > DIGIT_MAX) ? DIGIT_MAX : digit_i;

  // Advance the count on an append while room is left; drop it on clear
  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (append_i && (count_q < CW'(MAX_DIGITS))) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      in_range_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      in_range_q <= (rd_pos_i < count_q);
    end
  end

  // Digit storage: write at the count, read mirrored from the count
  assign rd_addr = count_q - CW'(1) - rd_pos_i;

  always_ff @(posedge clk_i) begin
    if (append_i && !clear_i && (count_q < CW'(MAX_DIGITS))) begin
      mem_q[count_q[AW - 1:0]] <= wr_digit;
    end
    rd_q <= mem_q[rd_addr[AW - 1:0]];
  end

  assign count_o    = count_q;
  assign rd_digit_o = in_range_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hdl/dlas_digit_alu.sv =====
// ----------------------------------------------------------------------------
// dlas_digit_alu: one-digit decimal adder/subtractor
// Adds two decimal digits with carry in, or subtracts the second digit and
// a borrow in from the first, giving a decimal digit and carry or borrow out.
// ----------------------------------------------------------------------------
`default_nettype none

module dlas_digit_alu (
  input  dlas_pkg::digit_t  a_i,
  input  dlas_pkg::digit_t  b_i,
  input  wire               carry_i,
  input  wire               sub_i,
  output dlas_pkg::digit_t  digit_o,
  output logic              carry_o
);

  import dlas_pkg::*;

  logic [4:0] sum_w;
  logic [4:0] sub_w;
  logic [4:0] a_w;

  assign a_w   = {1'b0, a_i};
  assign sum_w = a_w + {1'b0, b_i} + {4'd0, carry_i};
  assign sub_w = {1'b0, b_i} + {4'd0, carry_i};

  // Wrap the digit into range and flag carry or borrow
  always_comb begin
    if (sub_i) begin
      if (a_w < sub_w) begin
        digit_o = 4'(a_w + RADIX - sub_w);
        carry_o = 1'b1;
      end else begin
        digit_o = 4'(a_w - sub_w);
        carry_o = 1'b0;
      end
    end else begin
      if (sum_w >= RADIX) begin
        digit_o = 4'(sum_w - RADIX);
        carry_o = 1'b1;
      end else begin
        digit_o = sum_w[3:0];
        carry_o = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dlas_result_buf.sv =====
// ----------------------------------------------------------------------------
// dlas_result_buf: result digit buffer
// Single-port-write, single-port-read digit memory that collects result
// digits least significant first; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dlas_result_buf #(
  parameter int MAX_DIGITS = 32
) (
  input  wire                                clk_i,
  input  wire                                wr_en_i,
  input  wire [$clog2(MAX_DIGITS + 1) - 1:0] wr_addr_i,
  input  dlas_pkg::digit_t                   wr_digit_i,
  input  wire [$clog2(MAX_DIGITS + 1) - 1:0] rd_addr_i,
  output dlas_pkg::digit_t                   rd_digit_o
);

  import dlas_pkg::*;

  localparam int DEPTH = MAX_DIGITS + 1;

  digit_t mem_q [DEPTH];
  digit_t rd_q;

  // Write one digit, read one digit each cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_digit_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_digit_o = rd_q;

endmodule

`default_nettype wire

// ===== hdl/decimal_long_add_subtract.sv =====
// ----------------------------------------------------------------------------
// decimal_long_add_subtract: digit-serial decimal adder/subtractor
// Loads two unsigned decimal numbers digit by digit and emits their sum or
// difference one digit per cycle, most significant first, zeros trimmed.
// ----------------------------------------------------------------------------
// A transfer is taken when start is high and busy is low. Appends and clear
// leave busy low. A sum or difference over n = max of the two digit counts
// (at least 1) walks the operands least significant digit first through one
// digit adder, one digit per cycle, into a result buffer, then reads the
// buffer back from the top nonzero digit down. The result digits appear on
// res_valid_o, the last one in the first cycle with busy low. A negative
// difference gives a single result marked unavailable in the first cycle
// with busy low. Results are strobed for one cycle and cannot be held off.
// Digits above nine are stored as nine; appends to a full number are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_long_add_subtract #(
  parameter int MAX_DIGITS = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  wire [2:0]         action_i,
  input  dlas_pkg::digit_t  digit_i,
  output logic              res_valid_o,
  output dlas_pkg::digit_t  digit_res_o,
  output logic              unavailable_o,
  output logic              last_o
);

  import dlas_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic            sub_q;
  logic            carry_q;
  logic [CW - 1:0] rpos_q;
  logic [CW - 1:0] wpos_q;
  logic            v_q;
  logic [CW - 1:0] top_q;
  logic [CW - 1:0] eaddr_q;
  logic            out_valid_q;
  logic            out_unavail_q;
  logic            out_last_q;

  logic            accept;
  logic            append_a;
  logic            append_b;
  logic            clear;
  logic [CW - 1:0] cnt_a;
  logic [CW - 1:0] cnt_b;
  logic [CW - 1:0] n_max;
  logic [CW - 1:0] steps;
  digit_t          rd_a;
  digit_t          rd_b;
  digit_t          alu_digit;
  logic            alu_carry;
  logic            final_carry;
  logic            buf_we;
  logic [CW - 1:0] buf_waddr;
  digit_t          buf_wdata;
  digit_t          buf_rdata;

  // Decode the command transfer
  assign accept = start && (state_q == ST_IDLE);

  always_comb begin
    append_a = 1'b0;
    append_b = 1'b0;
    clear    = 1'b0;
    if (accept) begin
      unique case (action_i)
        ACT_APPEND_A: append_a = 1'b1;
        ACT_APPEND_B: append_b = 1'b1;
        ACT_CLEAR:    clear    = 1'b1;
        default:      ;
      endcase
    end
  end

  dlas_operand #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_operand_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear),
    .append_i   (append_a),
    .digit_i    (digit_i),
    .rd_pos_i   (rpos_q),
    .count_o    (cnt_a),
    .rd_digit_o (rd_a)
  );

  dlas_operand #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_operand_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (clear),
    .append_i   (append_b),
    .digit_i    (digit_i),
    .rd_pos_i   (rpos_q),
    .count_o    (cnt_b),
    .rd_digit_o (rd_b)
  );

  // Walk max(count) positions, at least one so an empty pair yields zero
  assign n_max = (cnt_a > cnt_b) ? cnt_a : cnt_b;
  assign steps = (n_max == '0) ? CW'(1) : n_max;

  dlas_digit_alu u_alu (
    .a_i     (rd_a),
    .b_i     (rd_b),
    .carry_i (carry_q),
    .sub_i   (sub_q),
    .digit_o (alu_digit),
    .carry_o (alu_carry)
  );

  // Sum carry out of the top position becomes one more digit
  assign final_carry = (state_q == ST_FINISH) && !sub_q && carry_q;

  always_comb begin
    buf_we    = 1'b0;
    buf_waddr = wpos_q;
    buf_wdata = alu_digit;
    if ((state_q == ST_CALC) && v_q) begin
      buf_we = 1'b1;
    end else if (final_carry) begin
      buf_we    = 1'b1;
      buf_waddr = steps;
      buf_wdata = DIGIT_ONE;
    end
  end

  dlas_result_buf #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_result_buf (
    .clk_i      (clk_i),
    .wr_en_i    (buf_we),
    .wr_addr_i  (buf_waddr),
    .wr_digit_i (buf_wdata),
    .rd_addr_i  (eaddr_q),
    .rd_digit_o (buf_rdata)
  );

  // Sequence the digit walk, the carry fixup and the emit pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      sub_q         <= 1'b0;
      carry_q       <= 1'b0;
      rpos_q        <= '0;
      wpos_q        <= '0;
      v_q           <= 1'b0;
      top_q         <= '0;
      eaddr_q       <= '0;
      out_valid_q   <= 1'b0;
      out_unavail_q <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      out_valid_q   <= 1'b0;
      out_unavail_q <= 1'b0;
      out_last_q    <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && ((action_i == ACT_SUM) || (action_i == ACT_DIFF))) begin
            state_q <= ST_CALC;
            sub_q   <= (action_i == ACT_DIFF);
            carry_q <= 1'b0;
            rpos_q  <= '0;
            v_q     <= 1'b0;
            top_q   <= '0;
          end
        end
        ST_CALC: begin
          // Issue operand reads, one position per cycle
          if (rpos_q < steps) begin
            rpos_q <= rpos_q + CW'(1);
            wpos_q <= rpos_q;
            v_q    <= 1'b1;
          end else begin
            v_q <= 1'b0;
          end
          // Fold the digit that was read last cycle
          if (v_q) begin
            carry_q <= alu_carry;
            if (alu_digit != '0) begin
              top_q <= wpos_q;
            end
            if (wpos_q == (steps - CW'(1))) begin
              state_q <= ST_FINISH;
              v_q     <= 1'b0;
            end
          end
        end
        ST_FINISH: begin
          if (sub_q && carry_q) begin
            out_valid_q   <= 1'b1;
            out_unavail_q <= 1'b1;
            out_last_q    <= 1'b1;
            state_q       <= ST_IDLE;
          end else begin
            eaddr_q <= final_carry ? steps : top_q;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Read back from the top digit down; data lines up with the strobe
          out_valid_q <= 1'b1;
          out_last_q  <= (eaddr_q == '0);
          if (eaddr_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            eaddr_q <= eaddr_q - CW'(1);
          end
        end
      endcase
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign res_valid_o   = out_valid_q;
  assign digit_res_o   = out_unavail_q ? '0 : buf_rdata;
  assign unavailable_o = out_unavail_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire
